### sv/rcfd_pkg.sv
// ----------------------------------------------------------------------------
// rcfd_pkg
// Shared types, codes and tables for the radio control frame decoder.
// ----------------------------------------------------------------------------
package rcfd_pkg;

	// widths fixed by the bus format
	localparam int unsigned BYTE_W     = 8;
	localparam int unsigned RADIO_W    = 2;
	localparam int unsigned FREQ_W     = 28;
	// full decoded sum: up to five pairs of nibbles, each pair at most 165
	localparam int unsigned FREQ_SUM_W = 34;
	localparam int unsigned BAND_W     = 8;
	localparam int unsigned MODE_W     = 4;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned MIN_LEN_W  = 4;

	localparam logic [FREQ_W-1:0] FREQ_MAX     = '1;
	localparam logic [MODE_W-1:0] MODE_UNKNOWN = 4'd8;
	localparam logic [BAND_W-1:0] BAND_NONE    = 8'd0;

	// register indexes of the configuration port
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CONTROLLER_ADDRESS = 3'd0,
		REG_MIN_FRAME_LENGTH   = 3'd1,
		REG_END_MARKER         = 3'd2,
		REG_FREQ_REPORT_CMD    = 3'd3,
		REG_FREQ_REPLY_CMD     = 3'd4,
		REG_MODE_REPORT_CMD    = 3'd5,
		REG_MODE_REPLY_CMD     = 3'd6
	} cfg_idx_t;

	// kind of update a closed frame carries
	typedef enum logic [1:0] {
		KIND_NONE = 2'd0,
		KIND_FREQ = 2'd1,
		KIND_MODE = 2'd2
	} kind_t;

	typedef struct packed {
		logic [BYTE_W-1:0]    controller_address;
		logic [MIN_LEN_W-1:0] min_frame_length;
		logic [BYTE_W-1:0]    end_marker;
		logic [BYTE_W-1:0]    freq_report_cmd;
		logic [BYTE_W-1:0]    freq_reply_cmd;
		logic [BYTE_W-1:0]    mode_report_cmd;
		logic [BYTE_W-1:0]    mode_reply_cmd;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		controller_address: 8'd224,
		min_frame_length:   4'd6,
		end_marker:         8'd253,
		freq_report_cmd:    8'd0,
		freq_reply_cmd:     8'd3,
		mode_report_cmd:    8'd1,
		mode_reply_cmd:     8'd4
	};

	// status of the input stage toward the decode stage
	typedef struct packed {
		logic valid;
		logic is_marker;
	} cap_ctl_t;

	// one decoded result
	typedef struct packed {
		logic              frame_valid;
		kind_t             kind;
		logic [FREQ_W-1:0] frequency_hz;
		logic [BAND_W-1:0] band_meters;
		logic [MODE_W-1:0] mode_index;
		logic [RADIO_W-1:0] source_radio;
		logic [BAND_W-1:0] band_radio_one;
		logic [BAND_W-1:0] band_radio_two;
	} result_t;

	// amateur band table, first match wins
	localparam int unsigned NUM_BANDS = 11;
	localparam logic [FREQ_W-1:0] BAND_LO [NUM_BANDS] = '{
		28'd1800000, 28'd3500000, 28'd5255000, 28'd7000000, 28'd10100000,
		28'd14000000, 28'd18068000, 28'd21000000, 28'd24890000, 28'd28000000,
		28'd50000000
	};
	localparam logic [FREQ_W-1:0] BAND_HI [NUM_BANDS] = '{
		28'd2000000, 28'd4000000, 28'd5405000, 28'd7300000, 28'd10150000,
		28'd14350000, 28'd18168000, 28'd21450000, 28'd24990000, 28'd29700000,
		28'd54000000
	};
	localparam logic [BAND_W-1:0] BAND_METERS [NUM_BANDS] = '{
		8'd160, 8'd80, 8'd60, 8'd40, 8'd30, 8'd20, 8'd17, 8'd15, 8'd12, 8'd10, 8'd6
	};

	// weight of digit pair n: 100 to the power n
	function automatic logic [FREQ_SUM_W-1:0] pow100(input int unsigned n);
		logic [FREQ_SUM_W-1:0] w;
		w = FREQ_SUM_W'(1);
		for (int unsigned k = 0; k < n; k++) begin
			w = w * FREQ_SUM_W'(100);
		end
		return w;
	endfunction

	// radio mode code to mode index
	function automatic logic [MODE_W-1:0] mode_of(input logic [BYTE_W-1:0] code);
		logic [MODE_W-1:0] m;
		case (code) inside
			[8'd0:8'd5]: m = code[MODE_W-1:0];
			8'd7:        m = 4'd6;
			8'd8:        m = 4'd7;
			default:     m = MODE_UNKNOWN;
		endcase
		return m;
	endfunction

endpackage

### sv/rcfd_cfg_regs.sv
// ----------------------------------------------------------------------------
// rcfd_cfg_regs
// Configuration register file, written through a valid/ready channel.
// ----------------------------------------------------------------------------
module rcfd_cfg_regs (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [rcfd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [rcfd_pkg::BYTE_W-1:0]       cfg_data,
	output rcfd_pkg::cfg_t                    cfg
);
	import rcfd_pkg::*;

	cfg_t cfg_q;

	// writes always accepted
	assign cfg_ready = 1'b1;

	// register writes, unknown index ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_idx_t'(cfg_index))
				REG_CONTROLLER_ADDRESS: cfg_q.controller_address <= cfg_data;
				REG_MIN_FRAME_LENGTH:   cfg_q.min_frame_length <= cfg_data[MIN_LEN_W-1:0];
				REG_END_MARKER:         cfg_q.end_marker <= cfg_data;
				REG_FREQ_REPORT_CMD:    cfg_q.freq_report_cmd <= cfg_data;
				REG_FREQ_REPLY_CMD:     cfg_q.freq_reply_cmd <= cfg_data;
				REG_MODE_REPORT_CMD:    cfg_q.mode_report_cmd <= cfg_data;
				REG_MODE_REPLY_CMD:     cfg_q.mode_reply_cmd <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### sv/rcfd_capture.sv
// ----------------------------------------------------------------------------
// rcfd_capture
// Input stage: frame buffer, byte position and the closing-byte register.
// ----------------------------------------------------------------------------
module rcfd_capture #(
	parameter int unsigned FRAME_CAPACITY = 11
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  rcfd_pkg::cfg_t                         cfg,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic [rcfd_pkg::BYTE_W-1:0]            rx_byte,
	input  logic [rcfd_pkg::RADIO_W-1:0]           radio_number,
	input  logic                                   out_busy,
	output rcfd_pkg::cap_ctl_t                     ctl,
	output logic [$clog2(FRAME_CAPACITY)-1:0]      pos_s1,
	output logic [rcfd_pkg::RADIO_W-1:0]           radio_s1,
	output logic [FRAME_CAPACITY-1:0][rcfd_pkg::BYTE_W-1:0] frame
);
	import rcfd_pkg::*;

	localparam int unsigned POS_W = $clog2(FRAME_CAPACITY);
	localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_CAPACITY - 1);

	logic [FRAME_CAPACITY-1:0][BYTE_W-1:0] frame_q;
	logic [POS_W-1:0] pos_q;
	logic             valid_s1;
	logic             marker_s1;
	logic             accept;
	logic             is_marker;
	logic             closes;

	// hold input only while a closed frame waits behind a stalled result
	assign in_stall  = valid_s1 && out_busy;
	assign accept    = in_valid && !in_stall;
	assign is_marker = (rx_byte == cfg.end_marker);
	assign closes    = is_marker || (pos_q == LAST_POS);

	// frame buffer, no reset
	always_ff @(posedge clk) begin
		if (accept) begin
			frame_q[pos_q] <= rx_byte;
		end
	end

	// byte position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (accept) begin
			pos_q <= closes ? '0 : pos_q + POS_W'(1);
		end
	end

	// closing byte enters the decode stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept && closes) begin
			valid_s1 <= 1'b1;
		end else if (!out_busy) begin
			valid_s1 <= 1'b0;
		end
	end

	// closing byte payload
	always_ff @(posedge clk) begin
		if (accept && closes) begin
			marker_s1 <= is_marker;
			pos_s1    <= pos_q;
			radio_s1  <= radio_number;
		end
	end

	assign ctl.valid     = valid_s1;
	assign ctl.is_marker = marker_s1;
	assign frame         = frame_q;

endmodule

### sv/rcfd_decode.sv
// ----------------------------------------------------------------------------
// rcfd_decode
// Frame checks, BCD frequency decode, band lookup and mode decode.
// ----------------------------------------------------------------------------
module rcfd_decode #(
	parameter int unsigned FRAME_CAPACITY        = 11,
	parameter int unsigned ADDRESS_POSITION      = 2,
	parameter int unsigned COMMAND_POSITION      = 4,
	parameter int unsigned DATA_POSITION         = 5,
	parameter int unsigned FREQUENCY_DIGIT_PAIRS = 4,
	parameter int unsigned MODE_OFFSET           = 0
) (
	input  rcfd_pkg::cfg_t                                  cfg,
	input  rcfd_pkg::cap_ctl_t                              ctl,
	input  logic [$clog2(FRAME_CAPACITY)-1:0]               pos_s1,
	input  logic [rcfd_pkg::RADIO_W-1:0]                    radio_s1,
	input  logic [FRAME_CAPACITY-1:0][rcfd_pkg::BYTE_W-1:0] frame,
	input  logic [rcfd_pkg::BAND_W-1:0]                     band_one,
	input  logic [rcfd_pkg::BAND_W-1:0]                     band_two,
	output rcfd_pkg::result_t                               res
);
	import rcfd_pkg::*;

	localparam int unsigned POS_W    = $clog2(FRAME_CAPACITY);
	localparam int unsigned CMP_W    = (POS_W > MIN_LEN_W) ? POS_W : MIN_LEN_W;
	localparam int unsigned MODE_POS = DATA_POSITION + MODE_OFFSET;

	logic [BYTE_W-1:0]     pair_byte [FREQUENCY_DIGIT_PAIRS];
	logic [FREQ_SUM_W-1:0] term [FREQUENCY_DIGIT_PAIRS];
	logic [BYTE_W-1:0]     mode_byte;
	logic [BYTE_W-1:0]     cmd;
	logic [FREQ_SUM_W-1:0] freq_sum;
	logic [BAND_W-1:0]     band;
	logic                  valid;
	logic                  is_freq;
	logic                  is_mode;
	kind_t                 kind;

	// data bytes, positions past the buffer read as zero
	for (genvar i = 0; i < FREQUENCY_DIGIT_PAIRS; i++) begin : g_pair
		localparam int unsigned P = DATA_POSITION + i;
		logic [BYTE_W-1:0] pair_val;
		if (P < FRAME_CAPACITY) begin : g_in
			assign pair_byte[i] = frame[P];
		end else begin : g_out
			assign pair_byte[i] = '0;
		end
		// low nibble plus ten times high nibble, then weight of the pair
		assign pair_val = BYTE_W'(pair_byte[i][3:0])
			+ BYTE_W'(pair_byte[i][7:4]) * BYTE_W'(10);
		assign term[i] = FREQ_SUM_W'(pair_val) * pow100(i);
	end

	if (MODE_POS < FRAME_CAPACITY) begin : g_mode_in
		assign mode_byte = frame[MODE_POS];
	end else begin : g_mode_out
		assign mode_byte = '0;
	end

	// frequency sum
	always_comb begin
		freq_sum = '0;
		for (int i = 0; i < FREQUENCY_DIGIT_PAIRS; i++) begin
			freq_sum = freq_sum + term[i];
		end
	end

	// band lookup on the full sum, first table entry wins
	always_comb begin
		band = BAND_NONE;
		for (int i = NUM_BANDS - 1; i >= 0; i--) begin
			if (freq_sum >= FREQ_SUM_W'(BAND_LO[i]) && freq_sum <= FREQ_SUM_W'(BAND_HI[i])) begin
				band = BAND_METERS[i];
			end
		end
	end

	// frame checks and command match, frequency first
	assign cmd   = frame[COMMAND_POSITION];
	assign valid = ctl.is_marker
		&& (CMP_W'(pos_s1) >= CMP_W'(cfg.min_frame_length))
		&& (frame[ADDRESS_POSITION] == cfg.controller_address);
	assign is_freq = valid && (cmd == cfg.freq_report_cmd || cmd == cfg.freq_reply_cmd);
	assign is_mode = valid && !is_freq
		&& (cmd == cfg.mode_report_cmd || cmd == cfg.mode_reply_cmd);

	always_comb begin
		if (is_freq) begin
			kind = KIND_FREQ;
		end else if (is_mode) begin
			kind = KIND_MODE;
		end else begin
			kind = KIND_NONE;
		end
	end

	// result fields and stored bands after this frame
	always_comb begin
		res.frame_valid    = valid;
		res.kind           = kind;
		res.source_radio   = radio_s1;
		res.frequency_hz   = '0;
		res.band_meters    = BAND_NONE;
		res.mode_index     = MODE_UNKNOWN;
		res.band_radio_one = band_one;
		res.band_radio_two = band_two;
		if (is_freq) begin
			res.frequency_hz = (freq_sum > FREQ_SUM_W'(FREQ_MAX)) ? FREQ_MAX
				: freq_sum[FREQ_W-1:0];
			res.band_meters = band;
			if (radio_s1 == 2'd1) begin
				res.band_radio_one = band;
			end
			if (radio_s1 == 2'd2) begin
				res.band_radio_two = band;
			end
		end
		if (is_mode) begin
			res.mode_index = mode_of(mode_byte);
		end
	end

endmodule

### sv/radio_control_frame_decoder_top.sv
// ----------------------------------------------------------------------------
// radio_control_frame_decoder_top
// Collects radio control bus bytes into frames and decodes closed frames.
// ----------------------------------------------------------------------------
// path: a closing byte passes the input register, then the result register,
//   on its way to the outputs
// throughput: one byte per cycle; input stalls only while a closed frame
//   waits in the decode register behind a stalled result
// reset: clears byte position, stored bands, configuration and valid flags;
//   the frame buffer holds no reset value
module radio_control_frame_decoder_top #(
	parameter int unsigned FRAME_CAPACITY        = 11,
	parameter int unsigned ADDRESS_POSITION      = 2,
	parameter int unsigned COMMAND_POSITION      = 4,
	parameter int unsigned DATA_POSITION         = 5,
	parameter int unsigned FREQUENCY_DIGIT_PAIRS = 4,
	parameter int unsigned MODE_OFFSET           = 0
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [rcfd_pkg::BYTE_W-1:0]       rx_byte,
	input  logic [rcfd_pkg::RADIO_W-1:0]      radio_number,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              frame_valid,
	output logic [1:0]                        update_kind,
	output logic [rcfd_pkg::FREQ_W-1:0]       frequency_hz,
	output logic [rcfd_pkg::BAND_W-1:0]       band_meters,
	output logic [rcfd_pkg::MODE_W-1:0]       mode_index,
	output logic [rcfd_pkg::RADIO_W-1:0]      source_radio,
	output logic [rcfd_pkg::BAND_W-1:0]       band_radio_one,
	output logic [rcfd_pkg::BAND_W-1:0]       band_radio_two,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [rcfd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [rcfd_pkg::BYTE_W-1:0]       cfg_data
);
	import rcfd_pkg::*;

	localparam int unsigned POS_W = $clog2(FRAME_CAPACITY);

	cfg_t     cfg;
	cap_ctl_t ctl;
	result_t  res;
	result_t  res_q;
	logic     out_valid_q;
	logic     out_busy;
	logic     advance;
	logic [POS_W-1:0]   pos_s1;
	logic [RADIO_W-1:0] radio_s1;
	logic [FRAME_CAPACITY-1:0][BYTE_W-1:0] frame;
	logic [BAND_W-1:0]  band_one_q;
	logic [BAND_W-1:0]  band_two_q;

	rcfd_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	rcfd_capture #(
		.FRAME_CAPACITY (FRAME_CAPACITY)
	) u_capture (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.rx_byte      (rx_byte),
		.radio_number (radio_number),
		.out_busy     (out_busy),
		.ctl          (ctl),
		.pos_s1       (pos_s1),
		.radio_s1     (radio_s1),
		.frame        (frame)
	);

	rcfd_decode #(
		.FRAME_CAPACITY        (FRAME_CAPACITY),
		.ADDRESS_POSITION      (ADDRESS_POSITION),
		.COMMAND_POSITION      (COMMAND_POSITION),
		.DATA_POSITION         (DATA_POSITION),
		.FREQUENCY_DIGIT_PAIRS (FREQUENCY_DIGIT_PAIRS),
		.MODE_OFFSET           (MODE_OFFSET)
	) u_decode (
		.cfg      (cfg),
		.ctl      (ctl),
		.pos_s1   (pos_s1),
		.radio_s1 (radio_s1),
		.frame    (frame),
		.band_one (band_one_q),
		.band_two (band_two_q),
		.res      (res)
	);

	// result register is full and not taken this cycle
	assign out_busy = out_valid_q && out_stall;
	assign advance  = ctl.valid && !out_busy;

	// result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_busy) begin
			out_valid_q <= ctl.valid;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res;
		end
	end

	// stored band per radio
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			band_one_q <= BAND_NONE;
			band_two_q <= BAND_NONE;
		end else if (advance) begin
			band_one_q <= res.band_radio_one;
			band_two_q <= res.band_radio_two;
		end
	end

	assign out_valid      = out_valid_q;
	assign frame_valid    = res_q.frame_valid;
	assign update_kind    = res_q.kind;
	assign frequency_hz   = res_q.frequency_hz;
	assign band_meters    = res_q.band_meters;
	assign mode_index     = res_q.mode_index;
	assign source_radio   = res_q.source_radio;
	assign band_radio_one = res_q.band_radio_one;
	assign band_radio_two = res_q.band_radio_two;

	// input held only behind a pending closed frame
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (ctl.valid && out_valid_q && out_stall))
		else $error("input stalled without a pending closed frame");

	// invalid frame carries no update
	a_invalid_none: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !frame_valid) |-> (update_kind == KIND_NONE))
		else $error("invalid frame reports an update");

	// non-frequency result has zero frequency and band
	a_freq_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && update_kind != KIND_FREQ) |-> (frequency_hz == '0 && band_meters == '0))
		else $error("frequency fields set without a frequency update");

	// frequency update of radio one shows in its stored band
	a_band_one: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && update_kind == KIND_FREQ && source_radio == 2'd1)
		|-> (band_radio_one == band_meters))
		else $error("radio one band not updated");

endmodule
